[hw/rtl/pfa_pkg.sv]
// Package for the partition fit allocator: request and result payload types,
// request type and policy codes, and parameter defaults.
// No dependencies.
package pfa_pkg;

  // Parameter defaults
  localparam int NUM_PARTITIONS_DEF = 8;
  localparam int SIZE_BITS_DEF      = 16;

  // Request type codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Placement policy codes; the unused code behaves as first fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Input request payload.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  part_index;
    logic [15:0] size_value;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic        success;
    logic [2:0]  chosen_index;
    logic [15:0] free_after;
  } out_res_t;

endpackage

[hw/rtl/partition_fit_allocator_unit.sv]
// Top level of the partition fit allocator: free-size store, scan sequencer
// with one shared compare unit, and the output register.
// Depends on pfa_pkg.
//
//  Channel   Ports                          Direction  Handshake
//  -------   -----------------------------  ---------  ------------------------
//  request   in_valid, in_ready, in_data    input      valid/ready
//  result    out_valid, out_ready, out_data output     valid/ready
//  config    cfg_we, cfg_wdata              input      write enable, no wait
//
// A load or an unknown request goes straight to the output step, a read makes
// one registered memory read, and an allocation scans all partitions:
// the scan reads one partition per cycle through the single memory read port
// and feeds one shared compare unit, then writes the chosen entry back.
// The result then moves into the output register once that is free.
// Reset clears all free sizes to zero at once through per-entry valid bits.
// A stalled result waits in the output register while the next request is
// taken; a second finished result waits in the sequencer until the slot frees.
module partition_fit_allocator_unit #(
  parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF,
  parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfa_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfa_pkg::out_res_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);

  import pfa_pkg::*;

  localparam int IDX_W = $clog2(NUM_PARTITIONS);
  localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_WB,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [1:0]        fit_policy_r;
  in_req_t           req_r;
  out_res_t          res_r;
  logic              out_valid_r;
  out_res_t          out_data_r;

  // Scan state
  logic [IDX_W-1:0]  scan_addr_r;
  logic              issue_act_r;
  logic              cmp_act_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              found_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [IDX_W-1:0]  sel_r;

  // Store
  logic [SIZE_BITS-1:0] mem [0:NUM_PARTITIONS-1];
  logic [NUM_PARTITIONS-1:0] valid_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [SIZE_BITS-1:0] rd_free;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  // Request decode and shared compare unit
  logic              accept;
  logic              in_range;
  logic [IDX_W-1:0]  in_addr;
  logic              fits;
  logic              take;
  logic [SIZE_BITS-1:0] new_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_range = (32'(in_data.part_index) < NUM_PARTITIONS);
  assign in_addr  = IDX_W'(in_data.part_index);

  // Entries never loaded since reset read as zero.
  assign rd_free = rd_vld_r ? rd_data_r : '0;

  // Compare the fetched entry against the request and the current choice.
  always_comb begin
    fits = (CMP_W'(rd_free) >= CMP_W'(req_r.size_value));
    take = 1'b0;
    if (cmp_act_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (fit_policy_r == POL_BEST) begin
        take = (rd_free < best_r);
      end else if (fit_policy_r == POL_WORST) begin
        take = (rd_free > best_r);
      end
    end
  end

  assign new_free = best_r - SIZE_BITS'(req_r.size_value);

  // Memory port selection: address from the request when idle, else the scan.
  always_comb begin
    rd_addr   = (state_r == S_IDLE) ? in_addr : scan_addr_r;
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = SIZE_BITS'(in_data.size_value);
    if (accept && in_data.req_type == REQ_LOAD && in_range) begin
      mem_we = 1'b1;
    end else if (state_r == S_WB && found_r) begin
      mem_we    = 1'b1;
      mem_waddr = sel_r;
      mem_wdata = new_free;
    end
  end

  // Store array with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Valid bits and the registered valid flag of the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // Policy register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
    end else if (cfg_we) begin
      fit_policy_r <= cfg_wdata;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      issue_act_r <= 1'b0;
      cmp_act_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      // The output register empties when taken, unless a new result moves in.
      if (out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r <= in_data;
            case (in_data.req_type)
              REQ_LOAD: begin
                res_r.success      <= in_range;
                res_r.chosen_index <= in_data.part_index;
                res_r.free_after   <= in_range ?
                                      16'(SIZE_BITS'(in_data.size_value)) : 16'd0;
                state_r            <= S_OUT;
              end
              REQ_READ: begin
                state_r <= S_READ;
              end
              REQ_ALLOC: begin
                scan_addr_r <= '0;
                issue_act_r <= 1'b1;
                cmp_act_r   <= 1'b0;
                found_r     <= 1'b0;
                state_r     <= S_SCAN;
              end
              default: begin
                res_r   <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          res_r.chosen_index <= req_r.part_index;
          if (32'(req_r.part_index) < NUM_PARTITIONS) begin
            res_r.success    <= 1'b1;
            res_r.free_after <= 16'(rd_free);
          end else begin
            res_r.success    <= 1'b0;
            res_r.free_after <= 16'd0;
          end
          state_r <= S_OUT;
        end
        S_SCAN: begin
          // Take the entry fetched last cycle.
          if (take) begin
            found_r <= 1'b1;
            best_r  <= rd_free;
            sel_r   <= cmp_idx_r;
          end
          // Issue the next read.
          cmp_act_r <= issue_act_r;
          cmp_idx_r <= scan_addr_r;
          if (issue_act_r) begin
            if (scan_addr_r == LAST_IDX) begin
              issue_act_r <= 1'b0;
            end else begin
              scan_addr_r <= scan_addr_r + 1'b1;
            end
          end
          if (!issue_act_r && !cmp_act_r) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          if (found_r) begin
            res_r.success      <= 1'b1;
            res_r.chosen_index <= 3'(sel_r);
            res_r.free_after   <= 16'(new_free);
          end else begin
            res_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/partition_fit_allocator_unit_test.sv]
// Self-checking testbench for partition_fit_allocator_unit: directed corners, random
// traffic under all fit policies, output backpressure, and a paced pause.
// Depends on pfa_pkg and the partition_fit_allocator_unit RTL.
`timescale 1ns / 100ps

module partition_fit_allocator_unit_test;
  import pfa_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] REQ_NOP   = 2'd3;
  localparam logic [1:0] POL_SPARE = 2'd3;

  localparam int NUM_PARTS     = 8;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_data;
  logic     cfg_we;
  logic [1:0] cfg_wdata;

  // Predictor state: free size per partition and the active policy.
  logic [15:0] free_tbl [NUM_PARTS];
  logic [1:0]  policy_q;

  out_res_t fit_results_due [$];
  int err_cnt;
  int n_reqs;
  int n_allocs;
  int n_no_fit;
  int cycle_cnt;
  bit idle_on;
  int rx_hold_len;

  partition_fit_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expected result of one request; updates the predicted free sizes.
  function automatic out_res_t predict_outcome(in_req_t r);
    out_res_t o;
    int sel;
    o = '0;
    sel = -1;
    case (r.req_type)
      REQ_LOAD: begin
        free_tbl[r.part_index] = r.size_value;
        o.success = 1'b1;
        o.chosen_index = r.part_index;
        o.free_after = r.size_value;
      end
      REQ_READ: begin
        o.success = 1'b1;
        o.chosen_index = r.part_index;
        o.free_after = free_tbl[r.part_index];
      end
      REQ_ALLOC: begin
        // Scan all partitions; ties keep the lowest index.
        for (int i = 0; i < NUM_PARTS; i++) begin
          if (free_tbl[i] >= r.size_value) begin
            if (sel < 0) begin
              sel = i;
            end else if (policy_q == POL_BEST && free_tbl[i] < free_tbl[sel]) begin
              sel = i;
            end else if (policy_q == POL_WORST && free_tbl[i] > free_tbl[sel]) begin
              sel = i;
            end
          end
        end
        if (sel >= 0) begin
          free_tbl[sel] = free_tbl[sel] - r.size_value;
          o.success = 1'b1;
          o.chosen_index = sel[2:0];
          o.free_after = free_tbl[sel];
        end
      end
      default: begin
        o = '0;
      end
    endcase
    return o;
  endfunction

  function automatic in_req_t make_req(logic [1:0] kind, logic [2:0] idx, logic [15:0] sz);
    in_req_t r;
    r.req_type = kind;
    r.part_index = idx;
    r.size_value = sz;
    return r;
  endfunction

  // Idle cycles before one request or one result; zero during no-idle stretches.
  function automatic int draw_gap();
    if (!idle_on) return 0;
    return ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(16, 0);
  endfunction

  // Random request, shaped around the predicted sizes so that allocations both fit and fail.
  function automatic in_req_t random_request();
    in_req_t r;
    int pick;
    int base;
    r.part_index = 3'($urandom_range(7, 0));
    r.size_value = 16'($urandom_range(16'hFFFF, 0));
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      r.req_type = REQ_LOAD;
      case ($urandom_range(3, 0))
        0: r.size_value = 16'($urandom_range(1023, 0));
        1: r.size_value = ($urandom_range(1, 0) == 0) ? 16'h0000 : 16'hFFFF;
        default: r.size_value = 16'($urandom_range(16'hFFFF, 0));
      endcase
    end else if (pick < 80) begin
      r.req_type = REQ_ALLOC;
      base = free_tbl[$urandom_range(7, 0)];
      case ($urandom_range(4, 0))
        0: r.size_value = 16'(base);
        1: r.size_value = 16'(base + 1);
        2: r.size_value = 16'($urandom_range(base, 0));
        3: r.size_value = 16'($urandom_range(15, 0));
        default: r.size_value = 16'($urandom_range(16'hFFFF, 0));
      endcase
    end else if (pick < 95) begin
      r.req_type = REQ_READ;
    end else begin
      r.req_type = REQ_NOP;
    end
    return r;
  endfunction

  // Send one request and hold it until accepted.
  task automatic send_req(in_req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  // The first edge lets the checker record a request accepted just before.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fit_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] pol);
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy_q = pol;
  endtask

  // Result receiver: random stalls per result, plus long hold-offs on request.
  initial begin
    int gap;
    gap = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) gap = draw_gap();
      if (rx_hold_len > 0) begin
        gap = rx_hold_len;
        rx_hold_len = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker and prediction on every accepted request.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (fit_results_due.size() == 0) begin
          $error("result with no request waiting: %p", out_data);
          err_cnt++;
        end else begin
          want = fit_results_due.pop_front();
          if (out_data.success !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, out_data.success);
            err_cnt++;
          end
          if (out_data.chosen_index !== want.chosen_index) begin
            $error("chosen_index: expected %0d, got %0d", want.chosen_index,
                   out_data.chosen_index);
            err_cnt++;
          end
          if (out_data.free_after !== want.free_after) begin
            $error("free_after: expected %0d, got %0d", want.free_after, out_data.free_after);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = predict_outcome(in_data);
        fit_results_due.push_back(want);
        n_reqs++;
        if (in_data.req_type == REQ_ALLOC) begin
          n_allocs++;
          if (!want.success) n_no_fit++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Corners: empty store after reset, size extremes, every policy, ties, no-fit, unknown type.
  task automatic test_directed_corners();
    idle_on = 1'b1;
    for (int i = 0; i < NUM_PARTS; i++) send_req(make_req(REQ_READ, i[2:0], 16'h0));
    send_req(make_req(REQ_ALLOC, 3'd2, 16'h0000));
    send_req(make_req(REQ_ALLOC, 3'd0, 16'h0001));
    send_req(make_req(REQ_LOAD, 3'd0, 16'hFFFF));
    send_req(make_req(REQ_LOAD, 3'd3, 16'h0000));
    send_req(make_req(REQ_LOAD, 3'd5, 16'd100));
    send_req(make_req(REQ_LOAD, 3'd7, 16'd100));
    send_req(make_req(REQ_ALLOC, 3'd0, 16'd50));
    write_policy(POL_BEST);
    send_req(make_req(REQ_ALLOC, 3'd0, 16'd100));
    send_req(make_req(REQ_ALLOC, 3'd0, 16'hFFFF));
    write_policy(POL_WORST);
    send_req(make_req(REQ_ALLOC, 3'd0, 16'd1));
    write_policy(POL_SPARE);
    send_req(make_req(REQ_ALLOC, 3'd0, 16'd60));
    send_req(make_req(REQ_NOP, 3'd7, 16'hFFFF));
    send_req(make_req(REQ_READ, 3'd7, 16'h0));
    send_req(make_req(REQ_READ, 3'd0, 16'h0));
    wait_all_results();
  endtask

  // Random traffic under each policy; the second half of each phase runs without idling.
  task automatic test_random_policies();
    logic [1:0] pols [4];
    pols = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE};
    foreach (pols[p]) begin
      write_policy(pols[p]);
      for (int k = 0; k < 130; k++) begin
        idle_on = (k < 65);
        send_req(random_request());
      end
    end
    idle_on = 1'b1;
    wait_all_results();
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    write_policy(logic'($urandom_range(2, 0)) ? POL_BEST : POL_WORST);
    idle_on = 1'b0;
    rx_hold_len = 200;
    for (int k = 0; k < 40; k++) send_req(random_request());
    idle_on = 1'b1;
    wait_all_results();
  endtask

  // Sender pauses mid-stream until every result is back, then resumes.
  task automatic test_paced_pause();
    write_policy(POL_FIRST);
    for (int k = 0; k < 30; k++) send_req(random_request());
    wait_all_results();
    for (int k = 0; k < 30; k++) send_req(random_request());
    wait_all_results();
  endtask

  initial begin
    err_cnt = 0;
    n_reqs = 0;
    n_allocs = 0;
    n_no_fit = 0;
    cycle_cnt = 0;
    idle_on = 1'b1;
    rx_hold_len = 0;
    policy_q = POL_FIRST;
    for (int i = 0; i < NUM_PARTS; i++) free_tbl[i] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_policies();
    test_output_backpressure();
    test_paced_pause();

    $display("Checked %0d requests, %0d of them allocations (%0d found no fit),",
             n_reqs, n_allocs, n_no_fit);
    $display("under first, best, worst and spare fit policies with random stalls.");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
